>>> sv/bucket_priority_queue_lifo_core_defines.svh
// Assertion macros shared by the queue RTL.
// Include with the bare file name; no other dependencies.
`ifndef BUCKET_PRIORITY_QUEUE_LIFO_CORE_DEFINES_SVH
`define BUCKET_PRIORITY_QUEUE_LIFO_CORE_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define BPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define BPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bpq_pkg.sv
// Shared types and constants for the bucket priority queue.
// No dependencies.
`default_nettype none
package bpq_pkg;
   localparam int NumKeysDefault    = 256;
   localparam int CapacityDefault   = 1024;
   localparam int EntryWidthDefault = 32;
   localparam int KeyW    = 8;
   localparam int DataW   = 32;
   localparam int CountW  = 11;
   localparam int StatusW = 2;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_PEEK   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;    // capture the request, start the key scan
      logic scan;    // advance the occupancy scan
      logic exec;    // apply the operation, build the response
   } bpq_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;
   } bpq_stat_type;
endpackage
`default_nettype wire

>>> sv/bpq_ctrl.sv
// Controller: sequences load, scan, memory read and execute for one beat.
// Depends on bpq_pkg.
`default_nettype none
module bpq_ctrl import bpq_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_fire,
   input  wire logic         rsp_free,
   input  bpq_stat_type      stat,
   output bpq_cmd_type       cmd,
   output logic              busy
);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_FETCH, S_EXEC} state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_READ;
         end
         // Bucket top read, then the slot link and payload read behind it.
         S_READ: state_in = S_FETCH;
         S_FETCH: state_in = S_EXEC;
         S_EXEC: begin
            if (rsp_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

>>> sv/bpq_datapath.sv
// Datapath: occupancy bits, bucket and slot memories, free list, counters.
// Depends on bpq_pkg; driven by bpq_ctrl commands.
`default_nettype none
module bpq_datapath import bpq_pkg::*; #(
   parameter int NUM_KEYS    = NumKeysDefault,
   parameter int CAPACITY    = CapacityDefault,
   parameter int ENTRY_WIDTH = EntryWidthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  bpq_cmd_type             cmd,
   output bpq_stat_type            stat,
   input  wire logic [1:0]         in_func,
   input  wire logic [KeyW-1:0]    in_key,
   input  wire logic [DataW-1:0]   in_data,
   output logic [StatusW-1:0]      res_status,
   output logic [KeyW-1:0]         res_key,
   output logic [DataW-1:0]        res_entry,
   output logic                    res_empty,
   output logic [CountW-1:0]       res_count
);
   localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int SW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CHUNK = 16;
   localparam int NCH = (NUM_KEYS + CHUNK - 1) / CHUNK;
   localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int NPAD = NCH * CHUNK;
   localparam logic [SW-1:0] SNULL = SW'(CAPACITY);

   logic [NPAD-1:0] occ_ff;
   logic [IW-1:0] top_mem [NUM_KEYS];
   logic [IW-1:0] link_mem [CAPACITY];
   logic [ENTRY_WIDTH-1:0] pay_mem [CAPACITY];

   logic [SW-1:0] free_head_ff, fresh_ff, count_ff;
   logic [1:0] func_ff;
   logic [KW-1:0] key_ff;
   logic [ENTRY_WIDTH-1:0] data_ff;
   logic [CW:0] chunk_ff;
   logic found_ff;
   logic [KW-1:0] min_ff;
   logic [IW-1:0] top_rd_ff, link_rd_ff, fl_rd_ff;
   logic [ENTRY_WIDTH-1:0] pay_rd_ff;
   logic top_rd_v;

   // Scan one 16-key chunk per cycle for the lowest occupied key.
   logic [CHUNK-1:0] chunk_bits;
   logic hit;
   logic [3:0] hit_pos;
   always_comb begin
      chunk_bits = occ_ff[chunk_ff[CW-1:0]*CHUNK +: CHUNK];
      hit = |chunk_bits;
      hit_pos = '0;
      for (int i = CHUNK - 1; i >= 0; i--)
         if (chunk_bits[i]) hit_pos = 4'(i);
   end
   assign stat.scan_done = found_ff || hit || (chunk_ff >= (CW+1)'(NCH - 1));

   logic [KW-1:0] key_sat;
   assign key_sat = (32'(in_key) >= NUM_KEYS) ? KW'(NUM_KEYS - 1) : KW'(in_key);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= in_func;
         key_ff   <= key_sat;
         data_ff  <= ENTRY_WIDTH'(in_data);
         chunk_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan && !found_ff) begin
         if (hit) begin
            found_ff <= 1'b1;
            min_ff   <= KW'(32'(chunk_ff[CW-1:0]) * CHUNK + 32'(hit_pos));
         end else begin
            chunk_ff <= chunk_ff + 1'b1;
         end
      end
   end

   // Registered memory reads, address settled after the scan.
   logic [KW-1:0] rd_key;
   assign rd_key = (func_ff == FUNC_INSERT) ? key_ff : min_ff;
   always_ff @(posedge clock) begin
      top_rd_ff <= top_mem[rd_key];
      fl_rd_ff  <= link_mem[free_head_ff[IW-1:0]];
   end
   always_ff @(posedge clock) begin
      link_rd_ff <= link_mem[top_rd_ff];
      pay_rd_ff  <= pay_mem[top_rd_ff];
   end
   assign top_rd_v = 1'b1;

   // Execute.
   logic ins_ok, rem_ok, srv_ok, fl_avail;
   logic [IW-1:0] new_slot;
   logic [SW-1:0] fl_next;
   logic occ_key;
   assign occ_key  = occ_ff[key_ff];
   assign fl_avail = free_head_ff < SNULL;
   assign ins_ok   = (func_ff == FUNC_INSERT) && (count_ff < SNULL);
   assign srv_ok   = (func_ff == FUNC_REMOVE || func_ff == FUNC_PEEK)
                     && (count_ff != '0) && found_ff && top_rd_v;
   assign rem_ok   = srv_ok && (func_ff == FUNC_REMOVE);
   always_comb begin
      if (fl_avail) new_slot = free_head_ff[IW-1:0];
      else if (fresh_ff >= SNULL) new_slot = IW'(CAPACITY - 1);
      else new_slot = fresh_ff[IW-1:0];
      fl_next = ({1'b0, fl_rd_ff} == free_head_ff) ? SNULL : SW'(fl_rd_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && ins_ok) begin
         pay_mem[new_slot]  <= data_ff;
         link_mem[new_slot] <= occ_key ? top_rd_ff : new_slot;
         top_mem[key_ff]    <= new_slot;
      end else if (cmd.exec && rem_ok) begin
         link_mem[top_rd_ff] <= fl_avail ? free_head_ff[IW-1:0] : top_rd_ff;
         if (link_rd_ff != top_rd_ff) top_mem[min_ff] <= link_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         free_head_ff <= SNULL;
         fresh_ff <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         unique case (func_ff)
            FUNC_INSERT: begin
               if (ins_ok) begin
                  occ_ff[key_ff] <= 1'b1;
                  count_ff <= count_ff + 1'b1;
                  if (fl_avail) free_head_ff <= fl_next;
                  else if (fresh_ff < SNULL) fresh_ff <= fresh_ff + 1'b1;
               end
            end
            FUNC_REMOVE: begin
               if (rem_ok) begin
                  if (link_rd_ff == top_rd_ff) occ_ff[min_ff] <= 1'b0;
                  free_head_ff <= SW'(top_rd_ff);
                  count_ff <= count_ff - 1'b1;
               end
            end
            FUNC_PEEK: ;
            FUNC_CLEAR: begin
               occ_ff <= '0;
               free_head_ff <= SNULL;
               fresh_ff <= '0;
               count_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // Response fields, taken by the top level on exec.
   logic [SW-1:0] count_after;
   always_comb begin
      res_status = STAT_OK;
      res_key = '0;
      res_entry = '0;
      count_after = count_ff;
      unique case (func_ff)
         FUNC_INSERT: begin
            if (ins_ok) count_after = count_ff + 1'b1;
            else res_status = STAT_FULL;
         end
         FUNC_REMOVE, FUNC_PEEK: begin
            if (srv_ok) begin
               res_key = KeyW'(min_ff);
               res_entry = DataW'(pay_rd_ff);
               if (rem_ok) count_after = count_ff - 1'b1;
            end else begin
               res_status = STAT_EMPTY;
            end
         end
         FUNC_CLEAR: count_after = '0;
         default: ;
      endcase
      res_count = CountW'(count_after);
      res_empty = (count_after == '0);
   end
endmodule
`default_nettype wire

>>> sv/bucket_priority_queue_lifo_core.sv
// Channel | dir | tdata fields (low bit up)            | tuser
// req     | in  | func[1:0] key[9:2] entry_data[41:10] | -
// rsp     | out | status[1:0] out_key[9:2] out_entry[41:10] is_empty[42]
//         |     |   entry_count[53:43]                  | -
// One beat at a time: the occupancy scan passes over empty 16-key chunks, then
// two registered memory reads (bucket top, then slot link and payload) run before execute.
// Synchronous reset clears occupancy, free list and counts; no clearing pass.
// A held response stalls the controller; req_tready is low while busy.
// Top level; depends on bpq_pkg, bpq_ctrl, bpq_datapath and the defines header.
`default_nettype none
`include "bucket_priority_queue_lifo_core_defines.svh"
module bucket_priority_queue_lifo_core import bpq_pkg::*; #(
   parameter int NUM_KEYS    = NumKeysDefault,
   parameter int CAPACITY    = CapacityDefault,
   parameter int ENTRY_WIDTH = EntryWidthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // func, key, entry_data, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata   // status, out_key, out_entry, is_empty,
                                        // entry_count, zero pad
);
   bpq_cmd_type  cmd;
   bpq_stat_type stat;
   logic busy, req_fire, rsp_free;
   logic [StatusW-1:0] r_status;
   logic [KeyW-1:0] r_key;
   logic [DataW-1:0] r_entry;
   logic r_empty;
   logic [CountW-1:0] r_count;
   logic rsp_valid_ff;
   logic [55:0] rsp_data_ff;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   bpq_ctrl u_ctrl (
      .clock, .reset, .req_fire, .rsp_free, .stat, .cmd, .busy
   );

   bpq_datapath #(.NUM_KEYS(NUM_KEYS), .CAPACITY(CAPACITY),
                  .ENTRY_WIDTH(ENTRY_WIDTH)) u_dp (
      .clock, .reset, .cmd, .stat,
      .in_func(req_tdata[1:0]), .in_key(req_tdata[9:2]),
      .in_data(req_tdata[41:10]),
      .res_status(r_status), .res_key(r_key), .res_entry(r_entry),
      .res_empty(r_empty), .res_count(r_count)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.exec) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.exec) rsp_data_ff <= {2'b0, r_count, r_empty, r_entry, r_key, r_status};
   end
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   `BPQ_ASSERT_IMP(a_no_accept_busy, clock, reset, busy, !req_tready, "accepted while busy")
   `BPQ_ASSERT_IMP(a_exec_free, clock, reset, cmd.exec, rsp_free, "response overwritten")
   `BPQ_ASSERT_NEXT(a_exec_valid, clock, reset, cmd.exec, rsp_tvalid, "response lost")
endmodule
`default_nettype wire
